### rtl/bstl_pkg.sv
// bstl_pkg: shared types, constants and the microcode rom of the binary split tile layout core
// depends on nothing; every other file refers to it by scoped names
package bstl_pkg;

	localparam int MAX_TILES = 64;
	localparam int IDX_W     = $clog2(MAX_TILES);
	localparam int CNT_W     = $clog2(MAX_TILES + 1);
	localparam int LVL_W     = 3;
	localparam int COORD_W   = 16;
	localparam int TC_W      = 7;
	localparam int GAP_W     = 10;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	localparam logic [GAP_W-1:0] SPLIT_GAP_RST      = 10'd10;
	localparam logic [GAP_W-1:0] EDGE_MARGIN_RST    = 10'd15;
	localparam logic [GAP_W-1:0] TASKBAR_HEIGHT_RST = 10'd40;

	// register indexes, byte address is four times the index
	localparam logic [1:0] REG_SPLIT_GAP      = 2'd0;
	localparam logic [1:0] REG_EDGE_MARGIN    = 2'd1;
	localparam logic [1:0] REG_TASKBAR_HEIGHT = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] top;
		logic signed [COORD_W-1:0] right;
		logic signed [COORD_W-1:0] bottom;
	} tile_t;

	typedef struct packed {
		logic [GAP_W-1:0] split_gap;
		logic [GAP_W-1:0] edge_margin;
		logic [GAP_W-1:0] taskbar_height;
	} cfg_t;

	typedef enum logic [2:0] {
		OP_IDLE  = 3'd0,
		OP_INIT  = 3'd1,
		OP_LEVEL = 3'd2,
		OP_SRD   = 3'd3,
		OP_SWB   = 3'd4,
		OP_SWA   = 3'd5,
		OP_ORD   = 3'd6,
		OP_OLD   = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER    = 3'd0,
		C_NO_START = 3'd1,
		C_FULL     = 3'd2,
		C_LEFT     = 3'd3,
		C_MORE     = 3'd4
	} cond_t;

	typedef logic [2:0] step_t;

	localparam step_t S_IDLE  = 3'd0;
	localparam step_t S_INIT  = 3'd1;
	localparam step_t S_LEVEL = 3'd2;
	localparam step_t S_SRD   = 3'd3;
	localparam step_t S_SWB   = 3'd4;
	localparam step_t S_SWA   = 3'd5;
	localparam step_t S_ORD   = 3'd6;
	localparam step_t S_OLD   = 3'd7;

	typedef struct packed {
		op_t   op;
		logic  wait_out;
		cond_t cond;
		step_t jmp;
		step_t seq;
	} ucode_t;

	typedef struct packed {
		op_t  op;
		logic hold;
	} ctrl_t;

	typedef struct packed {
		logic start;
		logic full;
		logic left;
		logic more;
		logic out_busy;
	} stat_t;

	// jump to jmp when the condition holds, else go to seq
	function automatic ucode_t ucode_rom(step_t s);
		ucode_t w;
		w = '{op: OP_IDLE, wait_out: 1'b0, cond: C_NO_START, jmp: S_IDLE, seq: S_INIT};
		case (s)
			S_IDLE:  w = '{op: OP_IDLE,  wait_out: 1'b0, cond: C_NO_START, jmp: S_IDLE,  seq: S_INIT};
			S_INIT:  w = '{op: OP_INIT,  wait_out: 1'b0, cond: C_NEVER,    jmp: S_LEVEL, seq: S_LEVEL};
			S_LEVEL: w = '{op: OP_LEVEL, wait_out: 1'b0, cond: C_FULL,     jmp: S_ORD,   seq: S_SRD};
			S_SRD:   w = '{op: OP_SRD,   wait_out: 1'b0, cond: C_NEVER,    jmp: S_SWB,   seq: S_SWB};
			S_SWB:   w = '{op: OP_SWB,   wait_out: 1'b0, cond: C_NEVER,    jmp: S_SWA,   seq: S_SWA};
			S_SWA:   w = '{op: OP_SWA,   wait_out: 1'b0, cond: C_LEFT,     jmp: S_SRD,   seq: S_LEVEL};
			S_ORD:   w = '{op: OP_ORD,   wait_out: 1'b0, cond: C_NEVER,    jmp: S_OLD,   seq: S_OLD};
			S_OLD:   w = '{op: OP_OLD,   wait_out: 1'b1, cond: C_MORE,     jmp: S_ORD,   seq: S_IDLE};
			default: w = '{op: OP_IDLE,  wait_out: 1'b0, cond: C_NO_START, jmp: S_IDLE,  seq: S_INIT};
		endcase
		return w;
	endfunction

endpackage

### rtl/bstl_if.sv
// bstl_if: valid/ready channels for the screen request and the tile results
// depends on bstl_pkg for the field widths
interface bstl_screen_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [bstl_pkg::COORD_W-1:0]   screen_left;
	logic signed [bstl_pkg::COORD_W-1:0]   screen_top;
	logic signed [bstl_pkg::COORD_W-1:0]   screen_right;
	logic signed [bstl_pkg::COORD_W-1:0]   screen_bottom;
	logic        [bstl_pkg::TC_W-1:0]      tile_count;

	modport source (output valid, screen_left, screen_top, screen_right, screen_bottom,
		tile_count, input ready);
	modport sink (input valid, screen_left, screen_top, screen_right, screen_bottom,
		tile_count, output ready);
endinterface

interface bstl_tile_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [bstl_pkg::COORD_W-1:0]   tile_left;
	logic signed [bstl_pkg::COORD_W-1:0]   tile_top;
	logic signed [bstl_pkg::COORD_W-1:0]   tile_right;
	logic signed [bstl_pkg::COORD_W-1:0]   tile_bottom;
	logic                                  last_tile;

	modport source (output valid, tile_left, tile_top, tile_right, tile_bottom, last_tile,
		input ready);
	modport sink (input valid, tile_left, tile_top, tile_right, tile_bottom, last_tile,
		output ready);
endinterface

### rtl/bstl_cfg.sv
// bstl_cfg: apb-style register file for the gap and taskbar settings
// depends on bstl_pkg
module bstl_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bstl_pkg::ADDR_W-1:0]   paddr,
	input  logic [bstl_pkg::DATA_W-1:0]   pwdata,
	output logic [bstl_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output bstl_pkg::cfg_t                cfg
);

	logic                            wr_en;
	logic [1:0]                      reg_idx;
	logic [bstl_pkg::GAP_W-1:0]      split_gap_q;
	logic [bstl_pkg::GAP_W-1:0]      edge_margin_q;
	logic [bstl_pkg::GAP_W-1:0]      taskbar_height_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_gap_q      <= bstl_pkg::SPLIT_GAP_RST;
			edge_margin_q    <= bstl_pkg::EDGE_MARGIN_RST;
			taskbar_height_q <= bstl_pkg::TASKBAR_HEIGHT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				bstl_pkg::REG_SPLIT_GAP:      split_gap_q      <= pwdata[bstl_pkg::GAP_W-1:0];
				bstl_pkg::REG_EDGE_MARGIN:    edge_margin_q    <= pwdata[bstl_pkg::GAP_W-1:0];
				bstl_pkg::REG_TASKBAR_HEIGHT: taskbar_height_q <= pwdata[bstl_pkg::GAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bstl_pkg::REG_SPLIT_GAP:      prdata = bstl_pkg::DATA_W'(split_gap_q);
			bstl_pkg::REG_EDGE_MARGIN:    prdata = bstl_pkg::DATA_W'(edge_margin_q);
			bstl_pkg::REG_TASKBAR_HEIGHT: prdata = bstl_pkg::DATA_W'(taskbar_height_q);
			default:                      prdata = '0;
		endcase
	end

	assign cfg.split_gap      = split_gap_q;
	assign cfg.edge_margin    = edge_margin_q;
	assign cfg.taskbar_height = taskbar_height_q;

endmodule

### rtl/bstl_seq.sv
// bstl_seq: step counter and microcode rom that sequence the layout datapath
// depends on bstl_pkg
module bstl_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  bstl_pkg::stat_t   status,
	output bstl_pkg::ctrl_t   ctrl
);

	bstl_pkg::step_t  step_q;
	bstl_pkg::step_t  step_nxt;
	bstl_pkg::ucode_t word;
	logic             hold;
	logic             take;

	assign word = bstl_pkg::ucode_rom(step_q);
	// stall on the output load while the previous tile is still waiting
	assign hold = word.wait_out && status.out_busy;

	always_comb begin
		case (word.cond)
			bstl_pkg::C_NEVER:    take = 1'b0;
			bstl_pkg::C_NO_START: take = !status.start;
			bstl_pkg::C_FULL:     take = status.full;
			bstl_pkg::C_LEFT:     take = status.left;
			bstl_pkg::C_MORE:     take = status.more;
			default:              take = 1'b0;
		endcase
	end

	assign step_nxt = hold ? step_q : (take ? word.jmp : word.seq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= bstl_pkg::S_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

	assign ctrl.op   = word.op;
	assign ctrl.hold = hold;

	a_hold_only_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.hold |-> ctrl.op == bstl_pkg::OP_OLD)
		else $error("sequencer stalled outside the output load step");

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		status.start |-> ctrl.op == bstl_pkg::OP_IDLE)
		else $error("request started while the sequencer was busy");

	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == bstl_pkg::S_OLD && !hold && !status.more) |=> step_q == bstl_pkg::S_IDLE)
		else $error("sequencer did not return to idle after the final tile");

endmodule

### rtl/bstl_dp.sv
// bstl_dp: tile store, split arithmetic, counters and output register
// depends on bstl_pkg and the channel interfaces in bstl_if
module bstl_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  bstl_pkg::cfg_t    cfg,
	input  bstl_pkg::ctrl_t   ctrl,
	output bstl_pkg::stat_t   status,
	bstl_screen_if.sink       screen,
	bstl_tile_if.source       tile
);

	localparam int IDX_W   = bstl_pkg::IDX_W;
	localparam int CNT_W   = bstl_pkg::CNT_W;
	localparam int COORD_W = bstl_pkg::COORD_W;

	bstl_pkg::tile_t  mem [bstl_pkg::MAX_TILES];
	bstl_pkg::tile_t  rdata_q;
	bstl_pkg::tile_t  init_q;
	bstl_pkg::tile_t  out_tile_q;
	logic             out_last_q;
	logic             out_valid_q;

	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              made_q;
	logic [IDX_W-1:0]              src_q;
	logic [IDX_W-1:0]              dst_q;
	logic [IDX_W-1:0]              ocnt_q;
	logic [bstl_pkg::LVL_W-1:0]    level_q;

	logic                  accept;
	logic                  load_out;
	logic [CNT_W-1:0]      count_sat;
	logic [COORD_W-1:0]    sg;
	logic [COORD_W-1:0]    tb;
	logic [COORD_W-1:0]    hg;
	logic [CNT_W:0]        dbl;
	logic [CNT_W:0]        newmade;

	logic                  we;
	logic [IDX_W-1:0]      waddr;
	bstl_pkg::tile_t       wdata;
	logic                  re;
	logic [IDX_W-1:0]      raddr;

	logic [COORD_W-1:0]    lo;
	logic [COORD_W-1:0]    hi;
	logic [COORD_W:0]      sum;
	logic [COORD_W:0]      sum_adj;
	logic [COORD_W-1:0]    mid;
	bstl_pkg::tile_t       half_a;
	bstl_pkg::tile_t       half_b;

	assign screen.ready = (ctrl.op == bstl_pkg::OP_IDLE);
	assign accept       = screen.valid && screen.ready;
	assign load_out     = (ctrl.op == bstl_pkg::OP_OLD) && !ctrl.hold;

	assign count_sat = (screen.tile_count > bstl_pkg::TC_W'(bstl_pkg::MAX_TILES))
		? CNT_W'(bstl_pkg::MAX_TILES) : CNT_W'(screen.tile_count);

	assign sg = COORD_W'(cfg.edge_margin);
	assign tb = COORD_W'(cfg.taskbar_height);
	assign hg = COORD_W'(cfg.split_gap[bstl_pkg::GAP_W-1:1]);

	// truncating midpoint: add one to a negative sum before the halving shift
	assign lo      = level_q[0] ? rdata_q.top : rdata_q.left;
	assign hi      = level_q[0] ? rdata_q.bottom : rdata_q.right;
	assign sum     = {lo[COORD_W-1], lo} + {hi[COORD_W-1], hi};
	assign sum_adj = sum + (COORD_W+1)'(sum[COORD_W]);
	assign mid     = sum_adj[COORD_W:1];

	always_comb begin
		half_a = rdata_q;
		half_b = rdata_q;
		if (level_q[0]) begin
			half_a.bottom = mid - hg;
			half_b.top    = mid + hg;
		end else begin
			half_a.right = mid - hg;
			half_b.left  = mid + hg;
		end
	end

	// splits run right to left in place: b lands at dst, a just below it
	always_comb begin
		we    = 1'b0;
		waddr = dst_q;
		wdata = half_b;
		re    = 1'b0;
		raddr = src_q;
		case (ctrl.op)
			bstl_pkg::OP_INIT: begin
				we    = 1'b1;
				waddr = '0;
				wdata = init_q;
			end
			bstl_pkg::OP_SWB: begin
				we = 1'b1;
			end
			bstl_pkg::OP_SWA: begin
				we    = 1'b1;
				waddr = dst_q - IDX_W'(1);
				wdata = half_a;
			end
			bstl_pkg::OP_SRD: begin
				re = 1'b1;
			end
			bstl_pkg::OP_ORD: begin
				re    = 1'b1;
				raddr = ocnt_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			init_q.left   <= screen.screen_left + sg;
			init_q.top    <= screen.screen_top + sg;
			init_q.right  <= screen.screen_right - sg;
			init_q.bottom <= screen.screen_bottom - sg - tb;
		end
		if (load_out) begin
			out_tile_q <= rdata_q;
			out_last_q <= !status.more;
		end
	end

	assign dbl     = {made_q, 1'b0};
	assign newmade = (dbl < {1'b0, count_q}) ? dbl : {1'b0, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			made_q      <= '0;
			src_q       <= '0;
			dst_q       <= '0;
			ocnt_q      <= '0;
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_sat;
			end
			case (ctrl.op)
				bstl_pkg::OP_INIT: begin
					made_q  <= CNT_W'(1);
					level_q <= '1;
				end
				bstl_pkg::OP_LEVEL: begin
					made_q  <= newmade[CNT_W-1:0];
					src_q   <= IDX_W'(made_q - CNT_W'(1));
					dst_q   <= IDX_W'(newmade - (CNT_W+1)'(1));
					level_q <= level_q + bstl_pkg::LVL_W'(1);
					ocnt_q  <= '0;
				end
				bstl_pkg::OP_SWA: begin
					dst_q <= dst_q - IDX_W'(2);
					src_q <= src_q - IDX_W'(1);
				end
				default: ;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
				ocnt_q      <= ocnt_q + IDX_W'(1);
			end else if (tile.valid && tile.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.start    = accept && (screen.tile_count != '0);
	assign status.full     = (made_q == count_q);
	assign status.left     = ({1'b0, dst_q} != ({1'b0, src_q} + (IDX_W+1)'(1)));
	assign status.more     = ((CNT_W'(ocnt_q) + CNT_W'(1)) != made_q);
	assign status.out_busy = out_valid_q && !tile.ready;

	assign tile.valid       = out_valid_q;
	assign tile.tile_left   = out_tile_q.left;
	assign tile.tile_top    = out_tile_q.top;
	assign tile.tile_right  = out_tile_q.right;
	assign tile.tile_bottom = out_tile_q.bottom;
	assign tile.last_tile   = out_last_q;

	a_split_order: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == bstl_pkg::OP_SRD |-> src_q < dst_q)
		else $error("split source caught up with its destination");

	a_made_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op != bstl_pkg::OP_IDLE && ctrl.op != bstl_pkg::OP_INIT)
		|-> (made_q != '0 && made_q <= count_q))
		else $error("tile count out of range");

	a_read_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == bstl_pkg::OP_ORD |-> CNT_W'(ocnt_q) < made_q)
		else $error("read-out beyond the tiles made");

endmodule

### rtl/binary_split_tile_layout_core.sv
// One screen request gives tile_count tile rectangles (saturated to 64, none for a count of zero),
// streamed in list order with last_tile on the final one. A microcoded sequencer drives a single
// 64-entry tile store with one read and one write port: an init step writes the first tile, each
// of the count-1 splits takes one read and two write steps, each split level adds a level step, and
// the read-out reads and then loads each tile, a load stalling while the previous tile waits.
// A new request is taken once the last tile is loaded into the output register, even while that
// tile still waits to be taken.
// Registers sit at byte addresses 0 (window gap), 4 (screen gap) and 8 (taskbar height).
module binary_split_tile_layout_core (
	input  logic                          clk,
	input  logic                          arst_n,
	bstl_screen_if.sink                   screen,
	bstl_tile_if.source                   tile,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bstl_pkg::ADDR_W-1:0]   paddr,
	input  logic [bstl_pkg::DATA_W-1:0]   pwdata,
	output logic [bstl_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	bstl_pkg::cfg_t  cfg;
	bstl_pkg::ctrl_t ctrl;
	bstl_pkg::stat_t status;

	bstl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bstl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	bstl_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.ctrl   (ctrl),
		.status (status),
		.screen (screen),
		.tile   (tile)
	);

endmodule
